### src/hcsp_pkg.sv
// Shared types, character codes and form codes for the hex colour string parser.
// No dependencies; hcsp_step, the top level and the bench use scoped names.
package hcsp_pkg;

  localparam int unsigned CountW   = 6;
  localparam int unsigned SigW     = 5;
  localparam int unsigned NibW     = 32;
  localparam int unsigned NibDigits = NibW / 4;
  localparam int unsigned ScanW    = 32;
  localparam int unsigned ScanMaxDigits = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [SigW-1:0]   SigFull  = SigW'(ScanMaxDigits);

  // String form codes
  localparam logic [1:0] FORM_NONE = 2'd0;
  localparam logic [1:0] FORM_HASH = 2'd1;
  localparam logic [1:0] FORM_OX   = 2'd2;
  localparam logic [1:0] FORM_BARE = 2'd3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X_LC = 8'h78;
  localparam logic [7:0] CH_X_UC = 8'h58;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [1:0]        form;
    logic [CountW-1:0] cnt;
    logic              first_zero;
    logic [NibW-1:0]   nib;
    logic [ScanW-1:0]  acc;      // low word of the hex scan
    logic [SigW-1:0]   sig;      // significant nibbles in the full 64-bit scan
    logic              ovf;
    logic              stopped;
    logic              bad;
  } state_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } res_t;

  localparam state_t StateReset = '0;

  // Nibble value of an ASCII hex digit; ok low when not a hex digit.
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

### src/hcsp_if.sv
// Handshake channels of the hex colour parser: character requests and results.
// Depends on nothing; payloads are plain vectors.
interface hcsp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hcsp_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, output valid_res, output red, output green,
                  output blue, output alpha, input ready);
  modport sink   (input valid, input valid_res, input red, input green,
                  input blue, input alpha, output ready);
endinterface

### src/hex_color_string_parser_unit.sv
// Top level of the hex colour string parser: parse state, result register.
// Depends on hcsp_pkg, hcsp_if (channel interfaces) and hcsp_step.

// Takes one character request per cycle on req_i (ch, last) while it is
// ready and, after the request marked last, delivers one result on res_o:
// valid_res and the red, green, blue and alpha bytes, all zero when the
// string is not a colour. Accepted forms: '#' with 3, 4, 6 or 8 hex digits
// (RGBA, short forms double each nibble, alpha 255 when absent), six bare
// hex digits (RGB), and "0x"/"0X" or eight bare characters scanned as ARGB
// up to the first non-hex character, saturating to all ones past sixteen
// significant digits. A NUL on the last request ends the string without
// being part of it. The result appears in the cycle after the last character
// is accepted, in a single output register. req_i.ready drops only while
// that register holds a result that res_o.ready does not take.
module hex_color_string_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcsp_req_if.sink        req_i,
  hcsp_res_if.source      res_o
);

  hcsp_pkg::state_t st_q, st_d;
  hcsp_pkg::state_t st_nxt;
  hcsp_pkg::res_t   res_q, res_c;
  logic             out_valid_q, out_valid_d;
  logic             req_acc;

  // Output register frees up in the same cycle it is taken
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  hcsp_step u_step (
    .cur_i  (st_q),
    .ch_i   (req_i.ch),
    .last_i (req_i.last),
    .nxt_o  (st_nxt),
    .res_o  (res_c)
  );

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && !res_o.ready;
    if (req_acc) begin
      // state returns to reset after every string
      st_d = req_i.last ? hcsp_pkg::StateReset : st_nxt;
      if (req_i.last) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= hcsp_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.last) res_q <= res_c;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.valid_res = res_q.valid_res;
  assign res_o.red       = res_q.red;
  assign res_o.green     = res_q.green;
  assign res_o.blue      = res_q.blue;
  assign res_o.alpha     = res_q.alpha;

endmodule

### src/hcsp_step.sv
// Per-character next-state and end-of-string result logic.
// Depends on hcsp_pkg (state_t, res_t, codes, hex_nib).
module hcsp_step (
  input  hcsp_pkg::state_t cur_i,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  output hcsp_pkg::state_t nxt_o,
  output hcsp_pkg::res_t   res_o
);

  logic [4:0]                 dec;
  logic                       is_hex;
  logic [3:0]                 d;
  logic [hcsp_pkg::CountW-1:0] k;
  logic                       take_dig;
  logic                       taken;
  hcsp_pkg::state_t           s;
  hcsp_pkg::state_t           f;
  logic [hcsp_pkg::ScanW-1:0] scan;
  logic [hcsp_pkg::CountW-1:0] dl;
  logic [hcsp_pkg::NibW-1:0]  n;

  assign dec    = hcsp_pkg::hex_nib(ch_i);
  assign is_hex = dec[4];
  assign d      = dec[3:0];
  assign taken  = !(last_i && ch_i == hcsp_pkg::CH_NUL);

  always_comb begin
    s        = cur_i;
    take_dig = 1'b0;
    k        = cur_i.cnt;
    if (cur_i.cnt == '0) begin
      s.first_zero = (ch_i == hcsp_pkg::CH_ZERO);
      if (ch_i == hcsp_pkg::CH_HASH) begin
        s.form = hcsp_pkg::FORM_HASH;
      end else begin
        s.form   = hcsp_pkg::FORM_BARE;
        take_dig = 1'b1;
      end
    end else if (cur_i.cnt == hcsp_pkg::CountW'(1) && cur_i.form == hcsp_pkg::FORM_BARE &&
                 cur_i.first_zero &&
                 (ch_i == hcsp_pkg::CH_X_LC || ch_i == hcsp_pkg::CH_X_UC)) begin
      s.form    = hcsp_pkg::FORM_OX;
      s.acc     = '0;
      s.sig     = '0;
      s.ovf     = 1'b0;
      s.stopped = 1'b0;
    end else begin
      take_dig = 1'b1;
      if (cur_i.form == hcsp_pkg::FORM_HASH) k = cur_i.cnt - hcsp_pkg::CountW'(1);
    end

    if (take_dig) begin
      if (!is_hex) s.bad = 1'b1;
      else if (k < hcsp_pkg::CountW'(hcsp_pkg::NibDigits))
        s.nib = {cur_i.nib[hcsp_pkg::NibW-5:0], d};
      if (!cur_i.stopped) begin
        if (!is_hex) begin
          s.stopped = 1'b1;
        end else begin
          // a seventeenth significant nibble passes 2^64-1
          if (cur_i.sig == hcsp_pkg::SigFull) s.ovf = 1'b1;
          s.acc = {cur_i.acc[hcsp_pkg::ScanW-5:0], d};
          if (cur_i.sig == '0)                     s.sig = {{(hcsp_pkg::SigW-1){1'b0}}, d != 4'd0};
          else if (cur_i.sig != hcsp_pkg::SigFull) s.sig = cur_i.sig + hcsp_pkg::SigW'(1);
        end
      end
    end
    if (cur_i.cnt != hcsp_pkg::CountMax) s.cnt = cur_i.cnt + hcsp_pkg::CountW'(1);
  end

  assign nxt_o = s;

  // Result from the state as it stands after this character
  always_comb begin
    f     = taken ? s : cur_i;
    scan  = f.ovf ? '1 : f.acc;
    dl    = f.cnt - hcsp_pkg::CountW'(1);
    n     = f.nib;
    res_o = '0;
    if (f.cnt != '0) begin
      case (f.form)
        hcsp_pkg::FORM_HASH: begin
          if (!f.bad) begin
            case (dl)
              6'd3: res_o = '{1'b1, {2{n[11:8]}}, {2{n[7:4]}}, {2{n[3:0]}},
                              hcsp_pkg::ALPHA_OPAQUE};
              6'd4: res_o = '{1'b1, {2{n[15:12]}}, {2{n[11:8]}}, {2{n[7:4]}},
                              {2{n[3:0]}}};
              6'd6: res_o = '{1'b1, n[23:16], n[15:8], n[7:0], hcsp_pkg::ALPHA_OPAQUE};
              6'd8: res_o = '{1'b1, n[31:24], n[23:16], n[15:8], n[7:0]};
              default: res_o = '0;
            endcase
          end
        end
        hcsp_pkg::FORM_OX: res_o = '{1'b1, scan[23:16], scan[15:8], scan[7:0], scan[31:24]};
        hcsp_pkg::FORM_BARE: begin
          if (f.cnt == 6'd6 && !f.bad)
            res_o = '{1'b1, n[23:16], n[15:8], n[7:0], hcsp_pkg::ALPHA_OPAQUE};
          else if (f.cnt == 6'd8)
            res_o = '{1'b1, scan[23:16], scan[15:8], scan[7:0], scan[31:24]};
        end
        default: res_o = '0;
      endcase
    end
  end

endmodule

### src/hcsp_checker.sv
// Port-level assertions for the hex colour parser, bound to the top level.
// Depends on hex_color_string_parser_unit ports only.
module hcsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_last_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_ok_i,
  input logic [31:0] res_chan_i
);

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result dropped while stalled");

  // an accepted last request yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_last_i) |=> res_valid_i)
    else $error("no result after last request");

  // a fresh result only follows a last request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(req_valid_i && req_ready_i && req_last_i))
    else $error("result without a last request");

  // an invalid string gives all channels zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ok_i) |-> (res_chan_i == 32'd0))
    else $error("invalid result with nonzero channels");

  // no request taken while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |-> !req_ready_i)
    else $error("request taken with output full");

endmodule

bind hex_color_string_parser_unit hcsp_checker u_hcsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_last_i  (req_i.last),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_ok_i    (res_o.valid_res),
  .res_chan_i  ({res_o.red, res_o.green, res_o.blue, res_o.alpha})
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for hex_color_string_parser_unit: random and directed colour strings.
// Depends on hcsp_pkg (form, character and result types) and hcsp_if (channel interfaces).
module tb_top;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  localparam int PhaseChars  = 420;   // characters queued per idling phase
  localparam int LongStall   = 400;   // receiver hold-off, in cycles

  logic clk_i;
  logic rst_ni;

  hcsp_req_if req_ch ();
  hcsp_res_if res_ch ();

  hex_color_string_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  char_req_t       chars_to_send[$];     // head is the request currently on offer
  hcsp_pkg::res_t  expected_colours[$];  // oldest first
  logic [7:0]      str_buf[$];           // string under construction
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              stall_armed;
  bit              req_fire = 1'b0;      // request accepted at the last rising edge
  int              errors   = 0;

  // ---------------------------------------------------------------------------
  // Parse-state mirror. Tracks the block's view of the string so far and
  // yields the colour expected when the string closes.
  // ---------------------------------------------------------------------------
  logic [1:0]  pf_form;
  int unsigned pf_count;     // characters taken, saturating
  logic [7:0]  pf_first;
  logic [31:0] pf_nibs;      // first eight digit nibbles, shifted in
  logic [63:0] pf_scan;      // full-width hex scan
  bit          pf_ovf;
  bit          pf_stop;
  bit          pf_bad;

  function automatic void clear_parse();
    pf_form  = hcsp_pkg::FORM_NONE;
    pf_count = 0;
    pf_first = '0;
    pf_nibs  = '0;
    pf_scan  = '0;
    pf_ovf   = 1'b0;
    pf_stop  = 1'b0;
    pf_bad   = 1'b0;
  endfunction

  // Legal digit counts of the '#' form
  function automatic int hash_len(int sel);
    case (sel)
      0:       return 3;
      1:       return 4;
      2:       return 6;
      default: return 8;
    endcase
  endfunction

  // -1 for anything that is not a hex digit
  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Digit position k counts from the first digit of the form.
  function automatic void feed_digit(logic [7:0] c, int unsigned k);
    int d;
    d = hex_digit_value(c);
    if (d < 0) pf_bad = 1'b1;
    else if (k < 8) pf_nibs = {pf_nibs[27:0], 4'(d)};
    if (!pf_stop) begin
      if (d < 0) begin
        pf_stop = 1'b1;
      end else begin
        // a non-zero top nibble shifted out means the scan passed 2^64-1
        if (pf_scan[63:60] != 4'd0) pf_ovf = 1'b1;
        pf_scan = {pf_scan[59:0], 4'(d)};
      end
    end
  endfunction

  function automatic void feed_char(logic [7:0] c);
    if (pf_count == 0) begin
      pf_first = c;
      if (c == hcsp_pkg::CH_HASH) begin
        pf_form = hcsp_pkg::FORM_HASH;
      end else begin
        pf_form = hcsp_pkg::FORM_BARE;
        feed_digit(c, 0);
      end
    end else if (pf_count == 1 && pf_form == hcsp_pkg::FORM_BARE &&
                 pf_first == hcsp_pkg::CH_ZERO &&
                 (c == hcsp_pkg::CH_X_LC || c == hcsp_pkg::CH_X_UC)) begin
      // "0x" prefix: restart the scan after it
      pf_form = hcsp_pkg::FORM_OX;
      pf_scan = '0;
      pf_ovf  = 1'b0;
      pf_stop = 1'b0;
    end else begin
      feed_digit(c, (pf_form == hcsp_pkg::FORM_HASH) ? pf_count - 1 : pf_count);
    end
    if (pf_count < hcsp_pkg::CountMax) pf_count++;
  endfunction

  function automatic hcsp_pkg::res_t rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a);
    hcsp_pkg::res_t c;
    c.valid_res = 1'b1;
    c.red       = r;
    c.green     = g;
    c.blue      = b;
    c.alpha     = a;
    return c;
  endfunction

  function automatic hcsp_pkg::res_t colour_of_string();
    hcsp_pkg::res_t c;
    logic [31:0]    n;
    logic [31:0]    w;
    c = '0;
    n = pf_nibs;
    w = pf_ovf ? '1 : pf_scan[31:0];
    if (pf_count != 0) begin
      case (pf_form)
        hcsp_pkg::FORM_HASH: begin
          if (!pf_bad) begin
            case (pf_count - 1)
              3: c = rgba({2{n[11:8]}}, {2{n[7:4]}}, {2{n[3:0]}},
                          hcsp_pkg::ALPHA_OPAQUE);
              4: c = rgba({2{n[15:12]}}, {2{n[11:8]}}, {2{n[7:4]}}, {2{n[3:0]}});
              6: c = rgba(n[23:16], n[15:8], n[7:0], hcsp_pkg::ALPHA_OPAQUE);
              8: c = rgba(n[31:24], n[23:16], n[15:8], n[7:0]);
              default: c = '0;
            endcase
          end
        end
        hcsp_pkg::FORM_OX: c = rgba(w[23:16], w[15:8], w[7:0], w[31:24]);
        hcsp_pkg::FORM_BARE: begin
          if (pf_count == 6 && !pf_bad)
            c = rgba(n[23:16], n[15:8], n[7:0], hcsp_pkg::ALPHA_OPAQUE);
          else if (pf_count == 8) c = rgba(w[23:16], w[15:8], w[7:0], w[31:24]);
        end
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  // A NUL on the closing request ends the string without being part of it.
  function automatic void colour_predict(logic [7:0] c, logic last);
    if (!(last && c == hcsp_pkg::CH_NUL)) feed_char(c);
    if (last) begin
      expected_colours.push_back(colour_of_string());
      clear_parse();
    end
  endfunction

  initial clear_parse();

  function automatic void check_byte(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    hcsp_pkg::res_t want;
    if (rst_ni) begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_colours.size() == 0) begin
          $error("result with no string closed: valid_res %0b rgba %0h %0h %0h %0h",
                 res_ch.valid_res, res_ch.red, res_ch.green, res_ch.blue, res_ch.alpha);
          errors++;
        end else begin
          want = expected_colours.pop_front();
          check_byte("valid_res", 8'(want.valid_res), 8'(res_ch.valid_res));
          check_byte("red", want.red, res_ch.red);
          check_byte("green", want.green, res_ch.green);
          check_byte("blue", want.blue, res_ch.blue);
          check_byte("alpha", want.alpha, res_ch.alpha);
        end
      end
      if (req_ch.valid && req_ch.ready) colour_predict(req_ch.ch, req_ch.last);
    end
  end

  // ---------------------------------------------------------------------------
  // Character driver, falling edge. Holds an offered request until it is
  // taken; otherwise idles at random or offers the head of the queue.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_fire) void'(chars_to_send.pop_front());
      if (!(req_ch.valid && !req_fire)) begin
        if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.ch    <= chars_to_send[0].ch;
          req_ch.last  <= chars_to_send[0].last;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver, falling edge. Once armed, it refuses results for a long
  // stretch so the result register fills and the block backs up its input.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_armed && !stall_done) begin
        stall_left = LongStall;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // String builders
  // ---------------------------------------------------------------------------
  int queued_chars = 0;

  // Close the string in str_buf: either last on its final character or a
  // trailing NUL request. An empty buffer always gets the NUL.
  function automatic void commit_string(bit nul_end);
    char_req_t r;
    if (str_buf.size() == 0) nul_end = 1'b1;
    foreach (str_buf[i]) begin
      r.ch   = str_buf[i];
      r.last = !nul_end && (i == str_buf.size() - 1);
      chars_to_send.push_back(r);
    end
    if (nul_end) begin
      r.ch   = hcsp_pkg::CH_NUL;
      r.last = 1'b1;
      chars_to_send.push_back(r);
    end
    queued_chars += str_buf.size() + int'(nul_end);
    str_buf.delete();
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endfunction

  // Hex digit of either case, or any byte at all with the given odds.
  function automatic logic [7:0] rand_char(int junk_pct);
    string digits;
    digits = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 99) < junk_pct) return 8'($urandom_range(0, 255));
    return digits[$urandom_range(0, 21)];
  endfunction

  // Mostly well-formed strings with random content; the rest is noise.
  function automatic void random_string();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // '#' form, mostly legal digit counts, sometimes 0..11 digits
      str_buf.push_back(hcsp_pkg::CH_HASH);
      if ($urandom_range(0, 3) != 0) n = hash_len($urandom_range(0, 3));
      else n = $urandom_range(0, 11);
      repeat (n) str_buf.push_back(rand_char(4));
    end else if (kind < 50) begin
      // "0x" scan, long enough now and then to overflow 64 bits
      str_buf.push_back(hcsp_pkg::CH_ZERO);
      str_buf.push_back($urandom_range(0, 1) ? hcsp_pkg::CH_X_LC : hcsp_pkg::CH_X_UC);
      n = $urandom_range(0, 20);
      repeat (n) str_buf.push_back(rand_char(10));
    end else if (kind < 62) begin
      repeat (6) str_buf.push_back(rand_char(5));
    end else if (kind < 78) begin
      repeat (8) str_buf.push_back(rand_char(12));
    end else if (kind < 97) begin
      n = $urandom_range(0, 12);
      repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // mostly long enough to saturate the character count
      str_buf.push_back($urandom_range(0, 1) ? hcsp_pkg::CH_HASH : rand_char(0));
      n = $urandom_range(60, 70);
      repeat (n) str_buf.push_back(rand_char(2));
    end
    commit_string($urandom_range(0, 4) == 0);
  endfunction

  task automatic drain_requests();
    while (chars_to_send.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = queued_chars + PhaseChars;
    while (queued_chars < target) random_string();
    drain_requests();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings, then three idling phases.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.ch     = '0;
    req_ch.last   = 1'b0;
    res_ch.ready  = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 49;
    stall_armed   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty string: a lone closing NUL
    commit_string(1'b1);
    // short '#' form closed by a NUL
    add_text("#Fa0");
    commit_string(1'b1);
    // prefix with no digits still parses, as zero
    add_text("0X");
    commit_string(1'b0);
    // seven digits after '#' is not a colour
    add_text("#1234567");
    commit_string(1'b0);
    // six bare digits, mixed case
    add_text("aB09fF");
    commit_string(1'b0);
    // eight bare characters with a NUL inside: the scan stops there
    add_text("12");
    str_buf.push_back(hcsp_pkg::CH_NUL);
    add_text("zzzzz");
    commit_string(1'b0);

    run_phase(31, 49);
    run_phase(49, 31);
    stall_armed = 1'b1;
    run_phase(0, 0);

    while (expected_colours.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### files.f
src/hcsp_pkg.sv
src/hcsp_if.sv
src/hcsp_step.sv
src/hex_color_string_parser_unit.sv
src/hcsp_checker.sv
bench/tb_top.sv
